// ===== hdl/ucdp_pkg.sv =====
// Package for the USB configuration descriptor parser.
// Holds descriptor codes, field positions, widths and the queue entry type.
// No dependencies.
package ucdp_pkg;

  // Descriptor type codes
  localparam logic [7:0] TYPE_INTERFACE = 8'd4;
  localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;

  // Minimum lengths for a usable descriptor
  localparam logic [7:0] IFACE_MIN_LEN = 8'd9;
  localparam logic [7:0] EP_MIN_LEN    = 8'd7;

  // Byte positions inside a descriptor
  localparam logic [7:0] POS_LENGTH    = 8'd0;
  localparam logic [7:0] POS_TYPE      = 8'd1;
  localparam logic [7:0] POS_IF_NUMBER = 8'd2;
  localparam logic [7:0] POS_IF_CLASS  = 8'd5;
  localparam logic [7:0] POS_IF_SUB    = 8'd6;
  localparam logic [7:0] POS_IF_PROTO  = 8'd7;
  localparam logic [7:0] POS_EP_ADDR   = 8'd2;
  localparam logic [7:0] POS_EP_ATTR   = 8'd3;
  localparam logic [7:0] POS_EP_MPS_LO = 8'd4;
  localparam logic [7:0] POS_EP_MPS_HI = 8'd5;
  localparam logic [7:0] POS_EP_INTVL  = 8'd6;

  // Transfer type bits of the attribute byte
  localparam logic [1:0] EP_TYPE_MASK = 2'b11;

  // Result kinds
  localparam logic KIND_ENDPOINT = 1'b0;
  localparam logic KIND_SUMMARY  = 1'b1;

  // Sizes
  localparam int CNT_W             = 5;
  localparam int SLOT_W            = 4;
  localparam int MAX_ENDPOINTS_DEF = 16;
  localparam int QUEUE_DEPTH       = 4;

  // One queued request: an endpoint record, a summary, or both
  typedef struct packed {
    logic              has_ep;
    logic              has_sum;
    logic [7:0]        ep_address;
    logic [1:0]        ep_type;
    logic [15:0]       ep_max_packet;
    logic [7:0]        ep_interval;
    logic [SLOT_W-1:0] ep_slot;
    logic [7:0]        iface_class;
    logic [7:0]        iface_subclass;
    logic [7:0]        iface_protocol;
    logic [CNT_W-1:0]  endpoint_count;
    logic              stopped_early;
  } entry_t;

endpackage

// ===== hdl/ucdp_front.sv =====
// Front end: accepts descriptor bytes, tracks position and fields,
// and pushes endpoint and summary requests into the queue. Uses ucdp_pkg.
module ucdp_front import ucdp_pkg::*; #(
  parameter int MAX_ENDPOINTS = MAX_ENDPOINTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       push_o,
  output entry_t     push_entry_o,
  input  logic       full_i
);

  logic [7:0]       byte_pos_q, byte_pos_d;
  logic [7:0]       desc_length_q, desc_length_d;
  logic [7:0]       desc_kind_q, desc_kind_d;
  logic             halted_q, halted_d;
  logic [7:0]       iface_number_q, iface_number_d;
  logic [7:0]       stage_a_q, stage_a_d;
  logic [7:0]       stage_b_q, stage_b_d;
  logic [15:0]      stage_word_q, stage_word_d;
  logic [7:0]       class_q, class_d;
  logic [7:0]       subclass_q, subclass_d;
  logic [7:0]       protocol_q, protocol_d;
  logic [CNT_W-1:0] stored_q, stored_d;
  logic             accept;
  logic             ep_hit;
  logic [7:0]       p;
  logic [7:0]       b;

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & ~full_i;
  assign p          = byte_pos_q;
  assign b          = data_byte_i;

  // Decode the byte and compute the next parser state
  always_comb begin
    byte_pos_d     = byte_pos_q;
    desc_length_d  = desc_length_q;
    desc_kind_d    = desc_kind_q;
    halted_d       = halted_q;
    iface_number_d = iface_number_q;
    stage_a_d      = stage_a_q;
    stage_b_d      = stage_b_q;
    stage_word_d   = stage_word_q;
    class_d        = class_q;
    subclass_d     = subclass_q;
    protocol_d     = protocol_q;
    stored_d       = stored_q;
    ep_hit         = 1'b0;

    if (!halted_q) begin
      if (p == POS_LENGTH) begin
        desc_length_d = b;
        if (b == 8'd0) halted_d = 1'b1;
      end else if (p == POS_TYPE) begin
        desc_kind_d = b;
      end else if (desc_kind_q == TYPE_INTERFACE) begin
        if (p == POS_IF_NUMBER) begin
          iface_number_d = b;
        end else if (p == POS_IF_CLASS) begin
          stage_a_d = b;
        end else if (p == POS_IF_SUB) begin
          stage_b_d = b;
        end else if (p == POS_IF_PROTO && desc_length_q >= IFACE_MIN_LEN &&
                     iface_number_q == 8'd0) begin
          class_d    = stage_a_q;
          subclass_d = stage_b_q;
          protocol_d = b;
        end
      end else if (desc_kind_q == TYPE_ENDPOINT) begin
        if (p == POS_EP_ADDR) begin
          stage_a_d = b;
        end else if (p == POS_EP_ATTR) begin
          stage_b_d = b;
        end else if (p == POS_EP_MPS_LO) begin
          stage_word_d = {stage_word_q[15:8], b};
        end else if (p == POS_EP_MPS_HI) begin
          stage_word_d = {b, stage_word_q[7:0]};
        end else if (p == POS_EP_INTVL && desc_length_q >= EP_MIN_LEN &&
                     stored_q < CNT_W'(MAX_ENDPOINTS)) begin
          ep_hit   = 1'b1;
          stored_d = stored_q + CNT_W'(1);
        end
      end
      // Advance within the descriptor, wrap to the next length byte
      if (!halted_d) begin
        if ({1'b0, p} + 9'd1 >= {1'b0, desc_length_d}) byte_pos_d = 8'd0;
        else byte_pos_d = p + 8'd1;
      end
    end
  end

  // Build the request for the back end
  always_comb begin
    push_entry_o                = '0;
    push_entry_o.has_ep         = ep_hit;
    push_entry_o.has_sum        = last_byte_i;
    if (ep_hit) begin
      push_entry_o.ep_address    = stage_a_q;
      push_entry_o.ep_type       = stage_b_q[1:0] & EP_TYPE_MASK;
      push_entry_o.ep_max_packet = stage_word_q;
      push_entry_o.ep_interval   = b;
      push_entry_o.ep_slot       = stored_q[SLOT_W-1:0];
    end
    if (last_byte_i) begin
      push_entry_o.iface_class    = class_d;
      push_entry_o.iface_subclass = subclass_d;
      push_entry_o.iface_protocol = protocol_d;
      push_entry_o.endpoint_count = stored_d;
      push_entry_o.stopped_early  = halted_d;
    end
  end

  assign push_o = accept & (ep_hit | last_byte_i);

  // Parser state; clear everything after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q     <= '0;
      desc_length_q  <= '0;
      desc_kind_q    <= '0;
      halted_q       <= 1'b0;
      iface_number_q <= '0;
      stage_a_q      <= '0;
      stage_b_q      <= '0;
      stage_word_q   <= '0;
      class_q        <= '0;
      subclass_q     <= '0;
      protocol_q     <= '0;
      stored_q       <= '0;
    end else if (accept) begin
      if (last_byte_i) begin
        byte_pos_q     <= '0;
        desc_length_q  <= '0;
        desc_kind_q    <= '0;
        halted_q       <= 1'b0;
        iface_number_q <= '0;
        stage_a_q      <= '0;
        stage_b_q      <= '0;
        stage_word_q   <= '0;
        class_q        <= '0;
        subclass_q     <= '0;
        protocol_q     <= '0;
        stored_q       <= '0;
      end else begin
        byte_pos_q     <= byte_pos_d;
        desc_length_q  <= desc_length_d;
        desc_kind_q    <= desc_kind_d;
        halted_q       <= halted_d;
        iface_number_q <= iface_number_d;
        stage_a_q      <= stage_a_d;
        stage_b_q      <= stage_b_d;
        stage_word_q   <= stage_word_d;
        class_q        <= class_d;
        subclass_q     <= subclass_d;
        protocol_q     <= protocol_d;
        stored_q       <= stored_d;
      end
    end
  end

endmodule

// ===== hdl/ucdp_queue.sv =====
// Short request queue between front and back end.
// Register-based FIFO of entry_t; uses ucdp_pkg.
module ucdp_queue import ucdp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output entry_t head_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  entry_t             mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W_Q-1:0] count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CNT_W_Q'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // Store requests
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_entry_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) count_q <= count_q + CNT_W_Q'(1);
      else if (!do_push && do_pop) count_q <= count_q - CNT_W_Q'(1);
    end
  end

endmodule

// ===== hdl/ucdp_back.sv =====
// Back end: turns queued requests into result items in an output register.
// An entry with both parts gives the endpoint record first. Uses ucdp_pkg.
module ucdp_back import ucdp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  entry_t            head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              kind_o,
  output logic [7:0]        ep_address_o,
  output logic [1:0]        ep_type_o,
  output logic [15:0]       ep_max_packet_o,
  output logic [7:0]        ep_interval_o,
  output logic [SLOT_W-1:0] ep_slot_o,
  output logic [7:0]        iface_class_o,
  output logic [7:0]        iface_subclass_o,
  output logic [7:0]        iface_protocol_o,
  output logic [CNT_W-1:0]  endpoint_count_o,
  output logic              stopped_early_o,
  output logic              run_end_o
);

  logic              valid_q, valid_d;
  logic              phase_q, phase_d;
  logic              load;
  logic              send_ep;
  logic              kind_d;
  logic              run_end_d;
  entry_t            res_q, res_d;
  logic              kind_q, run_end_q;

  assign load    = ~valid_q | out_ready_i;
  assign send_ep = head_i.has_ep & ~phase_q;

  // Pick the next result from the queue head
  always_comb begin
    valid_d   = valid_q;
    phase_d   = phase_q;
    pop_o     = 1'b0;
    res_d     = res_q;
    kind_d    = kind_q;
    run_end_d = run_end_q;
    if (load) begin
      valid_d = ~empty_i;
      if (!empty_i) begin
        res_d = '0;
        if (send_ep) begin
          kind_d              = KIND_ENDPOINT;
          res_d.ep_address    = head_i.ep_address;
          res_d.ep_type       = head_i.ep_type;
          res_d.ep_max_packet = head_i.ep_max_packet;
          res_d.ep_interval   = head_i.ep_interval;
          res_d.ep_slot       = head_i.ep_slot;
          run_end_d           = ~head_i.has_sum;
          if (head_i.has_sum) phase_d = 1'b1;
          else pop_o = 1'b1;
        end else begin
          kind_d               = KIND_SUMMARY;
          res_d.iface_class    = head_i.iface_class;
          res_d.iface_subclass = head_i.iface_subclass;
          res_d.iface_protocol = head_i.iface_protocol;
          res_d.endpoint_count = head_i.endpoint_count;
          res_d.stopped_early  = head_i.stopped_early;
          run_end_d            = 1'b1;
          phase_d              = 1'b0;
          pop_o                = 1'b1;
        end
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    kind_q    <= kind_d;
    run_end_q <= run_end_d;
  end

  assign out_valid_o      = valid_q;
  assign kind_o           = kind_q;
  assign ep_address_o     = res_q.ep_address;
  assign ep_type_o        = res_q.ep_type;
  assign ep_max_packet_o  = res_q.ep_max_packet;
  assign ep_interval_o    = res_q.ep_interval;
  assign ep_slot_o        = res_q.ep_slot;
  assign iface_class_o    = res_q.iface_class;
  assign iface_subclass_o = res_q.iface_subclass;
  assign iface_protocol_o = res_q.iface_protocol;
  assign endpoint_count_o = res_q.endpoint_count;
  assign stopped_early_o  = res_q.stopped_early;
  assign run_end_o        = run_end_q;

endmodule

// ===== hdl/usb_config_descriptor_parser_top.sv =====
// USB configuration descriptor parser, top level.
// Takes one byte per cycle while the queue has room; a result goes through the queue
// and then the back end's output register. A byte giving an endpoint record and a
// summary gives the record first. The queue holds up to four requests under stalls.
// Reset (rst_ni low, asynchronous) clears parser state, the queue and the output.
// Depends on ucdp_pkg, ucdp_front, ucdp_queue and ucdp_back.
module usb_config_descriptor_parser_top import ucdp_pkg::*; #(
  parameter int MAX_ENDPOINTS = MAX_ENDPOINTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              kind_o,
  output logic [7:0]        ep_address_o,
  output logic [1:0]        ep_type_o,
  output logic [15:0]       ep_max_packet_o,
  output logic [7:0]        ep_interval_o,
  output logic [SLOT_W-1:0] ep_slot_o,
  output logic [7:0]        iface_class_o,
  output logic [7:0]        iface_subclass_o,
  output logic [7:0]        iface_protocol_o,
  output logic [CNT_W-1:0]  endpoint_count_o,
  output logic              stopped_early_o,
  output logic              run_end_o
);

  logic   push, full, pop, empty;
  entry_t push_entry, head;

  ucdp_front #(
    .MAX_ENDPOINTS(MAX_ENDPOINTS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .push_o       (push),
    .push_entry_o (push_entry),
    .full_i       (full)
  );

  ucdp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .empty_o      (empty),
    .head_o       (head)
  );

  ucdp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .ep_address_o     (ep_address_o),
    .ep_type_o        (ep_type_o),
    .ep_max_packet_o  (ep_max_packet_o),
    .ep_interval_o    (ep_interval_o),
    .ep_slot_o        (ep_slot_o),
    .iface_class_o    (iface_class_o),
    .iface_subclass_o (iface_subclass_o),
    .iface_protocol_o (iface_protocol_o),
    .endpoint_count_o (endpoint_count_o),
    .stopped_early_o  (stopped_early_o),
    .run_end_o        (run_end_o)
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for usb_config_descriptor_parser_top.
// Drives descriptor buffers byte by byte and checks endpoint records and summaries
// against an in-bench descriptor walker. Depends on ucdp_pkg and the parser RTL.
module testbench;
  import ucdp_pkg::*;

  localparam int EP_LIMIT    = MAX_ENDPOINTS_DEF;
  localparam int IDLE_PCT    = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 60;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 16;
  localparam int BYTE_TARGET = 1000;
  localparam logic [7:0] TYPE_CONFIG = 8'h02;

  // One output request of the parser
  typedef struct packed {
    logic              kind;
    logic [7:0]        ep_address;
    logic [1:0]        ep_type;
    logic [15:0]       ep_max_packet;
    logic [7:0]        ep_interval;
    logic [SLOT_W-1:0] ep_slot;
    logic [7:0]        iface_class;
    logic [7:0]        iface_subclass;
    logic [7:0]        iface_protocol;
    logic [CNT_W-1:0]  endpoint_count;
    logic              stopped_early;
    logic              run_end;
  } walk_result_t;

  // Directed row: byte, last flag, pinned summary flag, pinned halted bit
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       pinned;
    logic       stop;
  } dir_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic [7:0]        data_byte_i = '0;
  logic              last_byte_i = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              out_ready_i = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic              kind_o;
  logic [7:0]        ep_address_o;
  logic [1:0]        ep_type_o;
  logic [15:0]       ep_max_packet_o;
  logic [7:0]        ep_interval_o;
  logic [SLOT_W-1:0] ep_slot_o;
  logic [7:0]        iface_class_o;
  logic [7:0]        iface_subclass_o;
  logic [7:0]        iface_protocol_o;
  logic [CNT_W-1:0]  endpoint_count_o;
  logic              stopped_early_o;
  logic              run_end_o;

  usb_config_descriptor_parser_top #(
    .MAX_ENDPOINTS(EP_LIMIT)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .ep_address_o     (ep_address_o),
    .ep_type_o        (ep_type_o),
    .ep_max_packet_o  (ep_max_packet_o),
    .ep_interval_o    (ep_interval_o),
    .ep_slot_o        (ep_slot_o),
    .iface_class_o    (iface_class_o),
    .iface_subclass_o (iface_subclass_o),
    .iface_protocol_o (iface_protocol_o),
    .endpoint_count_o (endpoint_count_o),
    .stopped_early_o  (stopped_early_o),
    .run_end_o        (run_end_o)
  );

  always #2 clk_i = ~clk_i;

  // Directed buffers: halting and lone length bytes, interface 0, endpoint ending
  // the buffer, a length-one descriptor before a cut-off endpoint, halt mid-buffer
  dir_row_t dir_tab [23] = '{
    '{8'h00, 1'b1, 1'b1, 1'b1},
    '{8'hFF, 1'b1, 1'b1, 1'b0},
    '{8'h09, 1'b0, 1'b0, 1'b0}, '{8'h04, 1'b0, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 1'b0}, '{8'h02, 1'b0, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h07, 1'b0, 1'b0, 1'b0}, '{8'h05, 1'b0, 1'b0, 1'b0}, '{8'h81, 1'b0, 1'b0, 1'b0},
    '{8'h03, 1'b0, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b1, 1'b0, 1'b0},
    '{8'h01, 1'b0, 1'b0, 1'b0}, '{8'h07, 1'b0, 1'b0, 1'b0}, '{8'h05, 1'b1, 1'b1, 1'b0},
    '{8'h00, 1'b0, 1'b0, 1'b0}, '{8'hAA, 1'b1, 1'b1, 1'b1}
  };

  walk_result_t      pending_q[$];
  logic [7:0]        buf_q[$];
  int                errors       = 0;
  int                bytes_sent   = 0;
  int                results_seen = 0;
  int                hold_left    = 0;
  int                stall_cycles = 0;
  bit                hold_done    = 1'b0;
  bit                quiet        = 1'b0;

  // Descriptor walker state
  logic [7:0]        walk_pos;
  logic [7:0]        walk_len;
  logic [7:0]        walk_type;
  logic              walk_halted;
  logic [7:0]        walk_ifnum;
  logic [7:0]        hold_a;
  logic [7:0]        hold_b;
  logic [15:0]       hold_mps;
  logic [7:0]        cls_code;
  logic [7:0]        sub_code;
  logic [7:0]        proto_code;
  logic [CNT_W-1:0]  ep_taken;

  task automatic clear_walk();
    walk_pos    = '0;
    walk_len    = '0;
    walk_type   = '0;
    walk_halted = 1'b0;
    walk_ifnum  = '0;
    hold_a      = '0;
    hold_b      = '0;
    hold_mps    = '0;
    cls_code    = '0;
    sub_code    = '0;
    proto_code  = '0;
    ep_taken    = '0;
  endtask

  // Advance the walker by one byte and queue the records and summary it yields
  task automatic walk_byte(input logic [7:0] b, input logic l);
    walk_result_t r;
    logic [7:0]   p;
    p = walk_pos;
    if (!walk_halted) begin
      if (p == POS_LENGTH) begin
        walk_len = b;
        if (b == 8'd0) walk_halted = 1'b1;
      end else if (p == POS_TYPE) begin
        walk_type = b;
      end else if (walk_type == TYPE_INTERFACE) begin
        if (p == POS_IF_NUMBER) walk_ifnum = b;
        else if (p == POS_IF_CLASS) hold_a = b;
        else if (p == POS_IF_SUB) hold_b = b;
        else if (p == POS_IF_PROTO && walk_len >= IFACE_MIN_LEN && walk_ifnum == 8'd0) begin
          cls_code   = hold_a;
          sub_code   = hold_b;
          proto_code = b;
        end
      end else if (walk_type == TYPE_ENDPOINT) begin
        if (p == POS_EP_ADDR) hold_a = b;
        else if (p == POS_EP_ATTR) hold_b = b;
        else if (p == POS_EP_MPS_LO) hold_mps[7:0] = b;
        else if (p == POS_EP_MPS_HI) hold_mps[15:8] = b;
        else if (p == POS_EP_INTVL && walk_len >= EP_MIN_LEN && ep_taken < EP_LIMIT) begin
          r               = '0;
          r.kind          = KIND_ENDPOINT;
          r.ep_address    = hold_a;
          r.ep_type       = hold_b[1:0] & EP_TYPE_MASK;
          r.ep_max_packet = hold_mps;
          r.ep_interval   = b;
          r.ep_slot       = ep_taken[SLOT_W-1:0];
          r.run_end       = !l;
          pending_q.push_back(r);
          ep_taken = ep_taken + 1'b1;
        end
      end
      if (!walk_halted) begin
        if ({1'b0, p} + 9'd1 >= {1'b0, walk_len}) walk_pos = '0;
        else walk_pos = p + 8'd1;
      end
    end
    if (l) begin
      r                = '0;
      r.kind           = KIND_SUMMARY;
      r.iface_class    = cls_code;
      r.iface_subclass = sub_code;
      r.iface_protocol = proto_code;
      r.endpoint_count = ep_taken;
      r.stopped_early  = walk_halted;
      r.run_end        = 1'b1;
      pending_q.push_back(r);
      clear_walk();
    end
  endtask

  // Offer one byte, hold it until accepted, then predict; a pinned row replaces
  // the predicted summary with the one typed in the table
  task automatic send_byte(input logic [7:0] b, input logic l, input logic pinned,
                           input logic stop);
    walk_result_t want;
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= l;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    walk_byte(b, l);
    if (pinned) begin
      want               = '0;
      want.kind          = KIND_SUMMARY;
      want.stopped_early = stop;
      want.run_end       = 1'b1;
      void'(pending_q.pop_back());
      pending_q.push_back(want);
    end
  endtask

  // Drop valid and hold until every expected request has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_q.size() != 0);
  endtask

  // Append one descriptor of random payload; return where it starts
  task automatic put_desc(input int len, input logic [7:0] dtype, output int at);
    at = buf_q.size();
    buf_q.push_back(len[7:0]);
    if (len > 1) buf_q.push_back(dtype);
    for (int k = 2; k < len; k++) buf_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Build one descriptor buffer: mostly well-formed sets, some noise, halts and cuts
  task automatic build_buffer(input bit big);
    int mode;
    int at;
    int len;
    int n_if;
    int n_ep;
    int cut;
    buf_q.delete();
    mode = $urandom_range(0, 99);
    if (mode < 12 && !big) begin
      repeat ($urandom_range(1, 24)) buf_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      put_desc(9, TYPE_CONFIG, at);
      n_if = big ? 1 : $urandom_range(1, 3);
      for (int i = 0; i < n_if; i++) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 14) : 9;
        put_desc(len, TYPE_INTERFACE, at);
        if (len > 2 && $urandom_range(0, 3) != 0) buf_q[at + 2] = 8'h00;
        n_ep = big ? $urandom_range(EP_LIMIT + 1, EP_LIMIT + 4) : $urandom_range(0, 4);
        for (int j = 0; j < n_ep; j++) begin
          // skip over class-specific or unknown descriptors now and then
          if ($urandom_range(0, 9) == 0) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(21, 255) : $urandom_range(1, 20);
            put_desc(len, 8'($urandom_range(0, 255)), at);
          end
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 12) : 7;
          put_desc(len, TYPE_ENDPOINT, at);
        end
      end
      if ($urandom_range(0, 19) == 0) begin
        buf_q.push_back(8'h00);
        repeat ($urandom_range(0, 6)) buf_q.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, buf_q.size() - 1);
        repeat (cut) void'(buf_q.pop_back());
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  task automatic check_result();
    walk_result_t want;
    if (pending_q.size() == 0) begin
      $error("unexpected request: kind %0d run_end %0d", kind_o, run_end_o);
      errors++;
    end else begin
      want = pending_q.pop_front();
      check_field("kind", 16'(want.kind), 16'(kind_o));
      check_field("ep_address", 16'(want.ep_address), 16'(ep_address_o));
      check_field("ep_type", 16'(want.ep_type), 16'(ep_type_o));
      check_field("ep_max_packet", want.ep_max_packet, ep_max_packet_o);
      check_field("ep_interval", 16'(want.ep_interval), 16'(ep_interval_o));
      check_field("ep_slot", 16'(want.ep_slot), 16'(ep_slot_o));
      check_field("iface_class", 16'(want.iface_class), 16'(iface_class_o));
      check_field("iface_subclass", 16'(want.iface_subclass), 16'(iface_subclass_o));
      check_field("iface_protocol", 16'(want.iface_protocol), 16'(iface_protocol_o));
      check_field("endpoint_count", 16'(want.endpoint_count), 16'(endpoint_count_o));
      check_field("stopped_early", 16'(want.stopped_early), 16'(stopped_early_o));
      check_field("run_end", 16'(want.run_end), 16'(run_end_o));
    end
  endtask

  // Receive side: check accepted requests, stall at random, hold off once for long
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      check_result();
      results_seen++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int nbuf;
    clear_walk();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].pinned, dir_tab[i].stop);
    end
    drain();

    // Random buffers: a quiet stretch, one drained pause, periodic overflow buffers
    nbuf = 0;
    while (bytes_sent < BYTE_TARGET + $size(dir_tab)) begin
      quiet = (nbuf >= 6 && nbuf < 12);
      if (nbuf == 15) drain();
      build_buffer(nbuf % 12 == 7);
      foreach (buf_q[i]) send_byte(buf_q[i], i == buf_q.size() - 1, 1'b0, 1'b0);
      nbuf++;
    end
    quiet = 1'b0;

    drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
